### rtl/xcpf_pkg.sv
// Shared constants for the XOR-checked packet framer.
package xcpf_pkg;

  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 16;
  localparam int BUFFER_BYTES  = 16;
  localparam int RESULT_LIMIT  = 16;
  localparam int ADDR_W        = $clog2(BUFFER_BYTES);
  localparam int FILL_W        = $clog2(BUFFER_BYTES + 1);

  localparam logic [BYTE_W-1:0] CHECK_SEED  = 8'hFF;
  localparam int                OPCODE_BIT  = 7;
  localparam logic [1:0]        KIND_STATED = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  // Expected packet length from the opcode and the second byte.
  function automatic byte_t length_from_head(input byte_t head, input byte_t second);
    byte_t len;
    begin
      if (head[6:5] == KIND_STATED) begin
        len = second;
      end else begin
        len = {5'd0, head[6:5], 1'b0} + 8'd2;
      end
      return len;
    end
  endfunction

endpackage

### rtl/xcpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xcpf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/xor_checked_packet_framer_top.sv
// Top level of the XOR-checked packet framer.
//
//   channel | ports                               | word
//   --------+-------------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_received_byte| one byte from the line
//   out     | out_valid, out_ready, out_*         | one packet byte or an error
//
// A byte that completes no packet gives no word. A good packet of n bytes
// then streams min(n,16) words, each fetched through the packet RAM's
// registered read port (issue read, then present). A bad packet gives one
// error word. Input is held off while words are delivered; out stalls hold
// the word. Reset clears fill, check, counters and the sequencer; RAM
// contents are undefined and only written entries are ever read.
module xor_checked_packet_framer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [xcpf_pkg::BYTE_W-1:0] in_received_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [xcpf_pkg::BYTE_W-1:0] out_packet_byte,
  output logic                        out_last_of_packet,
  output logic                        out_checksum_error,
  output logic [xcpf_pkg::CNT_W-1:0]  out_good_packet_count,
  output logic [xcpf_pkg::CNT_W-1:0]  out_error_packet_count
);
  import xcpf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  byte_t             chk_r, chk_nxt;
  byte_t             head_r, head_nxt;
  byte_t             second_r, second_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [CNT_W-1:0]  err_r, err_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] last_idx_r, last_idx_nxt;
  byte_t             out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;

  logic              accept;
  logic              opcode;
  logic [FILL_W-1:0] fill_eff;
  logic [FILL_W-1:0] n;
  byte_t             n8;
  byte_t             chk_eff;
  byte_t             second_eff;
  byte_t             exp_len;
  logic              full;
  logic              complete;
  logic              good;
  byte_t             last8;

  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  byte_t             ram_rd_data;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign opcode   = in_received_byte[OPCODE_BIT];

  // An opcode restarts the packet before the full check.
  assign fill_eff   = opcode ? '0 : fill_r;
  assign chk_eff    = opcode ? CHECK_SEED : chk_r;
  assign full       = (fill_eff == FILL_W'(BUFFER_BYTES));
  assign n          = fill_eff + FILL_W'(1);
  assign n8         = BYTE_W'(n);
  assign second_eff = (fill_eff == FILL_W'(1)) ? in_received_byte : second_r;
  assign exp_len    = length_from_head(head_r, second_eff);
  assign complete   = !full && (n8 >= 8'd2) && (n8 == exp_len);
  assign good       = complete && (chk_eff == in_received_byte);
  assign last8      = (n8 > BYTE_W'(RESULT_LIMIT)) ? BYTE_W'(RESULT_LIMIT - 1) : (n8 - 8'd1);

  assign ram_wr_en   = accept && !full;
  assign ram_rd_en   = (accept && good) || ((state_r == ST_OUT) && out_ready && !out_last_r);
  assign ram_rd_addr = (state_r == ST_IDLE) ? '0 : (idx_r + ADDR_W'(1));

  xcpf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_eff[ADDR_W-1:0]),
    .wr_data (in_received_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    chk_nxt      = chk_r;
    head_nxt     = head_r;
    second_nxt   = second_r;
    good_nxt     = good_r;
    err_nxt      = err_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fill_nxt = full ? fill_eff : n;
          chk_nxt  = (full || complete) ? chk_eff : (chk_eff ^ in_received_byte);
          if (!full && (fill_eff == '0)) begin
            head_nxt = in_received_byte;
          end
          if (!full && (fill_eff == FILL_W'(1))) begin
            second_nxt = in_received_byte;
          end
          if (complete) begin
            if (good) begin
              good_nxt     = good_r + CNT_W'(1);
              idx_nxt      = '0;
              last_idx_nxt = last8[ADDR_W-1:0];
              state_nxt    = ST_WAIT;
            end else begin
              err_nxt      = err_r + CNT_W'(1);
              out_byte_nxt = '0;
              out_last_nxt = 1'b1;
              out_err_nxt  = 1'b1;
              state_nxt    = ST_OUT;
            end
          end
        end
      end
      ST_WAIT: begin
        out_byte_nxt = ram_rd_data;
        out_last_nxt = (idx_r == last_idx_r);
        out_err_nxt  = 1'b0;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            // advance to the next stored byte; its read is issued in this same cycle
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_WAIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      chk_r   <= CHECK_SEED;
      good_r  <= '0;
      err_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      chk_r   <= chk_nxt;
      good_r  <= good_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    second_r   <= second_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid              = (state_r == ST_OUT);
  assign out_packet_byte        = out_byte_r;
  assign out_last_of_packet     = out_last_r;
  assign out_checksum_error     = out_err_r;
  assign out_good_packet_count  = good_r;
  assign out_error_packet_count = err_r;

endmodule

### bench/xor_checked_packet_framer_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the XOR-checked packet framer: directed byte table, then random packets.
module xor_checked_packet_framer_top_test;
  import xcpf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 96;
  localparam int SETTLE_CYCLES = 64;
  localparam int REPORT_MAX   = 10;
  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 4;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_ERROR, ROW_PAIR} row_kind_t;
  typedef enum logic [1:0] {KIND_TWO, KIND_FOUR, KIND_SIX, KIND_LEN_BYTE} head_kind_t;

  typedef struct packed {
    byte_t            data;
    logic             last;
    logic             chk_err;
    logic [CNT_W-1:0] good_cnt;
    logic [CNT_W-1:0] err_cnt;
  } framed_word_t;

  typedef struct {
    byte_t            data;
    row_kind_t        kind;
    byte_t            head;
    logic [CNT_W-1:0] good_cnt;
    logic [CNT_W-1:0] err_cnt;
  } stim_row_t;

  // Typed rows: QUIET gives no word, ERROR one error word, PAIR a two-byte good packet, PREDICT modeled words.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, ROW_QUIET,   8'h00, 16'd0, 16'd0},  // leading byte is not an opcode
    '{8'h01, ROW_ERROR,   8'h00, 16'd0, 16'd1},
    '{8'h80, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h7F, ROW_PAIR,    8'h80, 16'd1, 16'd1},
    '{8'h80, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h00, ROW_ERROR,   8'h00, 16'd1, 16'd2},
    '{8'h55, ROW_QUIET,   8'h00, 16'd0, 16'd0},  // stored after completion
    '{8'hA0, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h12, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h34, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h79, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'hC0, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h01, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h02, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h04, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h08, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h30, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'hE0, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h03, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'h1C, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'hFF, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h00, ROW_PREDICT, 8'h00, 16'd0, 16'd0},  // stated length zero never completes
    '{8'h7F, ROW_PREDICT, 8'h00, 16'd0, 16'd0},
    '{8'hE5, ROW_QUIET,   8'h00, 16'd0, 16'd0},
    '{8'h01, ROW_PREDICT, 8'h00, 16'd0, 16'd0}   // stated length one never completes
  };

  int unsigned phase_idle  [N_PHASES] = '{0, 63, 0, 37};
  int unsigned phase_stall [N_PHASES] = '{0, 0, 63, 37};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  byte_t               in_received_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  byte_t               out_packet_byte;
  logic                out_last_of_packet;
  logic                out_checksum_error;
  logic [CNT_W-1:0]    out_good_packet_count;
  logic [CNT_W-1:0]    out_error_packet_count;

  // Framer shadow state
  byte_t               pkt_bytes [BUFFER_BYTES];
  int unsigned         pkt_fill = 0;
  byte_t               pkt_len = '0;
  byte_t               pkt_xor = CHECK_SEED;
  logic [CNT_W-1:0]    good_seen = '0;
  logic [CNT_W-1:0]    err_seen = '0;

  framed_word_t        fresh_words[$];
  framed_word_t        pending_words[$];
  byte_t               burst[$];

  int unsigned         idle_pct = 0;
  int unsigned         stall_pct = 0;
  int unsigned         miss_count = 0;
  int unsigned         words_checked = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         kept_random = 0;
  int unsigned         cycle_count = 0;

  xor_checked_packet_framer_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_received_byte       (in_received_byte),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_packet_byte        (out_packet_byte),
    .out_last_of_packet     (out_last_of_packet),
    .out_checksum_error     (out_checksum_error),
    .out_good_packet_count  (out_good_packet_count),
    .out_error_packet_count (out_error_packet_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic string show_word(input framed_word_t w);
    return $sformatf("byte=%02h last=%0b err=%0b good=%0d bad=%0d",
                     w.data, w.last, w.chk_err, w.good_cnt, w.err_cnt);
  endfunction

  task automatic log_miss(input string why);
    miss_count++;
    if (miss_count <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $time, why);
    end
  endtask

  // Advance the shadow framer by one byte; fresh_words gets the words it should cause.
  task automatic frame_byte(input byte_t b, output bit kept);
    int unsigned n_out;
    fresh_words.delete();
    kept = 1'b0;
    if (b[OPCODE_BIT]) begin
      pkt_fill = 0;
      pkt_len  = '0;
      pkt_xor  = CHECK_SEED;
    end
    if (pkt_fill < BUFFER_BYTES) begin
      kept = 1'b1;
      pkt_bytes[pkt_fill] = b;
      pkt_fill++;
      if (pkt_fill >= 2 && pkt_len == '0) begin
        pkt_len = (pkt_bytes[0][6:5] == KIND_STATED) ? pkt_bytes[1]
                                                     : byte_t'(2 * pkt_bytes[0][6:5] + 2);
      end
      if (pkt_fill < 2 || pkt_fill != pkt_len) begin
        pkt_xor ^= b;
      end else if (pkt_xor != b) begin
        err_seen++;
        fresh_words.push_back(framed_word_t'{8'h00, 1'b1, 1'b1, good_seen, err_seen});
      end else begin
        good_seen++;
        n_out = (pkt_fill > RESULT_LIMIT) ? RESULT_LIMIT : pkt_fill;
        for (int unsigned i = 0; i < n_out; i++) begin
          fresh_words.push_back(framed_word_t'{pkt_bytes[i], (i + 1 == n_out), 1'b0,
                                               good_seen, err_seen});
        end
      end
    end
  endtask

  // Hold valid and the byte until the word is taken; idle first at random.
  task automatic send_byte(input byte_t b);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid         <= 1'b1;
    in_received_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // One packet, mostly well formed: opcode, optional length byte, data, check byte,
  // sometimes trailing bytes. The rest is raw line noise.
  task automatic build_burst();
    int unsigned roll;
    int unsigned want_len;
    head_kind_t  kind;
    byte_t       chk;
    burst.delete();
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 20)) burst.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      kind = head_kind_t'($urandom_range(0, 3));
      burst.push_back({1'b1, kind, 5'($urandom_range(0, 31))});
      if (kind == KIND_LEN_BYTE) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) want_len = $urandom_range(2, 8);
        else if (roll < 80) want_len = BUFFER_BYTES;
        else if (roll < 90) want_len = $urandom_range(0, 1);
        else want_len = $urandom_range(BUFFER_BYTES + 1, 127);
        burst.push_back(byte_t'(want_len));
      end else begin
        want_len = 2 * kind + 2;
      end
      if (want_len >= 2 && want_len <= BUFFER_BYTES) begin
        while (burst.size() < want_len - 1) burst.push_back(byte_t'($urandom_range(0, 127)));
        if (burst.size() < want_len) begin
          chk = CHECK_SEED;
          foreach (burst[k]) chk ^= burst[k];
          if ($urandom_range(0, 99) < 20) chk = byte_t'($urandom_range(0, 127));
          burst.push_back(chk);
        end
        if ($urandom_range(0, 99) < 25) begin
          repeat ($urandom_range(1, 6)) burst.push_back(byte_t'($urandom_range(0, 127)));
        end
      end else begin
        // never completes: run into a full store now and then
        repeat ($urandom_range(0, BUFFER_BYTES + 4))
          burst.push_back(byte_t'($urandom_range(0, 127)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    framed_word_t got;
    framed_word_t want;
    if (rst_n && out_valid && out_ready) begin
      got = framed_word_t'{out_packet_byte, out_last_of_packet, out_checksum_error,
                           out_good_packet_count, out_error_packet_count};
      words_checked++;
      if (pending_words.size() == 0) begin
        log_miss({"unexpected word ", show_word(got)});
      end else begin
        want = pending_words.pop_front();
        if (got.data !== want.data || got.last !== want.last ||
            got.chk_err !== want.chk_err || got.good_cnt !== want.good_cnt ||
            got.err_cnt !== want.err_cnt) begin
          log_miss({"expected ", show_word(want), ", got ", show_word(got)});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d words still expected",
               cycle_count, pending_words.size());
      $display("xor_checked_packet_framer_top regression: fail");
      $finish;
    end
  end

  initial begin
    bit kept;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].data);
      frame_byte(directed_rows[r].data, kept);
      bytes_sent++;
      case (directed_rows[r].kind)
        ROW_PREDICT: begin
          foreach (fresh_words[k]) pending_words.push_back(fresh_words[k]);
        end
        ROW_ERROR: begin
          pending_words.push_back(framed_word_t'{8'h00, 1'b1, 1'b1,
                                  directed_rows[r].good_cnt, directed_rows[r].err_cnt});
        end
        ROW_PAIR: begin
          pending_words.push_back(framed_word_t'{directed_rows[r].head, 1'b0, 1'b0,
                                  directed_rows[r].good_cnt, directed_rows[r].err_cnt});
          pending_words.push_back(framed_word_t'{directed_rows[r].data, 1'b1, 1'b0,
                                  directed_rows[r].good_cnt, directed_rows[r].err_cnt});
        end
        default: begin
        end
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // hold the line until every word of the previous phase is out
      wait_for_drain();
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      while (kept_random < (ph + 1) * RANDOM_BYTES / N_PHASES) begin
        build_burst();
        foreach (burst[k]) begin
          send_byte(burst[k]);
          frame_byte(burst[k], kept);
          bytes_sent++;
          if (kept) kept_random++;
          foreach (fresh_words[w]) pending_words.push_back(fresh_words[w]);
        end
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d line bytes under four idle and stall mixes: %0d good packets, %0d bad.",
             bytes_sent, good_seen, err_seen);
    $display("Compared %0d output words, %0d mismatches.", words_checked, miss_count);
    if (miss_count == 0 && pending_words.size() == 0) begin
      $display("xor_checked_packet_framer_top regression: pass");
    end else begin
      $display("xor_checked_packet_framer_top regression: fail");
    end
    $finish;
  end

endmodule
